FILE: sv/lpf_pkg.sv
// Shared types and constants for the four-pole ladder lowpass filter.
// Coefficient widths, fixed-point constants, register indexes and step codes.
// No dependencies.
package lpf_pkg;

  localparam int COEF_BITS = 20;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int CUTOFF_BITS = 16;
  localparam int RESON_BITS = 15;
  localparam int STEP_BITS = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESONANCE = 8'd1;

  localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 16'd32768;
  localparam logic [RESON_BITS-1:0] RESON_RESET = 15'd0;

  // Q16 constants
  localparam logic [16:0] K_1P16 = 17'd76022;
  localparam logic [16:0] K_0P15 = 17'd9830;
  localparam logic [16:0] K_GAIN = 17'd22946;
  localparam logic [16:0] K_0P3 = 17'd19661;
  localparam logic [16:0] K_ONE = 17'h10000;

  // Sequencer steps; each issues one multiply, written back one step later
  localparam logic [STEP_BITS-1:0] SQ_F = 5'd0;
  localparam logic [STEP_BITS-1:0] SQ_Q1 = 5'd1;
  localparam logic [STEP_BITS-1:0] SQ_FSQ = 5'd2;
  localparam logic [STEP_BITS-1:0] SQ_Q2 = 5'd3;
  localparam logic [STEP_BITS-1:0] SQ_T = 5'd4;
  localparam logic [STEP_BITS-1:0] SQ_F4 = 5'd5;
  localparam logic [STEP_BITS-1:0] SQ_FB = 5'd6;
  localparam logic [STEP_BITS-1:0] SQ_GAIN = 5'd7;
  localparam logic [STEP_BITS-1:0] SQ_FBK = 5'd8;
  localparam logic [STEP_BITS-1:0] SQ_Q3 = 5'd9;
  localparam logic [STEP_BITS-1:0] SQ_SG = 5'd10;
  localparam logic [STEP_BITS-1:0] SQ_Q4 = 5'd11;
  localparam logic [STEP_BITS-1:0] SQ_O1 = 5'd12;
  localparam logic [STEP_BITS-1:0] SQ_O2 = 5'd13;
  localparam logic [STEP_BITS-1:0] SQ_O3 = 5'd14;
  localparam logic [STEP_BITS-1:0] SQ_O4 = 5'd15;
  localparam logic [STEP_BITS-1:0] SQ_END = 5'd16;

endpackage

FILE: sv/lpf_if.sv
// Handshake channel interfaces for the ladder lowpass filter: sample in,
// sample out and configuration write. Depends on lpf_pkg.
interface lpf_in_if #(parameter int W = 24) ();
  logic valid;
  logic ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface lpf_out_if #(parameter int W = 24) ();
  logic valid;
  logic ready;
  logic signed [W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface lpf_cfg_if ();
  logic valid;
  logic ready;
  logic [lpf_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lpf_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/lpf_mul.sv
// Shared signed multiplier with registered product and Q16 / Q13 rounding.
// Depends on lpf_pkg.
module lpf_mul #(
  parameter int AW = 32
) (
  input  logic                                   clk,
  input  logic signed [AW-1:0]                   a,
  input  logic signed [lpf_pkg::COEF_BITS-1:0]   b,
  output logic signed [AW+4:0]                   r16,
  output logic signed [AW+7:0]                   r13
);
  localparam int PW = AW + lpf_pkg::COEF_BITS;

  logic signed [PW-1:0] p;
  logic signed [PW:0] ps16;
  logic signed [PW:0] ps13;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

  // round half up, then floor shift
  assign ps16 = {p[PW-1], p} + (PW+1)'(32768);
  assign ps13 = {p[PW-1], p} + (PW+1)'(4096);
  assign r16 = ps16[PW:16];
  assign r13 = ps13[PW:13];

endmodule

FILE: sv/ladder_lowpass_filter.sv
// Four-pole resonant ladder lowpass filter, top level with sequencer.
// Depends on lpf_pkg, lpf_if (channel interfaces) and lpf_mul.
//
// Use: samples arrive on din (valid/ready, signed Q1.23 sample_in), results
// leave on dout (valid/ready, signed saturated sample_out), one result per
// sample. cfg writes cutoff (index 0) and resonance (index 1); other
// indexes are ignored. cfg is always ready and is meant to be written only
// while the filter is idle.
// Each sample runs 16 multiplies through one shared multiplier, one per
// cycle: six for the coefficients from cutoff and resonance, ten for the
// feedback, gain and the four stages. After the last product is written
// back, the output state loads the saturated result into the output
// register; the multiplier schedule keeps one sample in work at a time.
// din.ready is low while a sample is being worked on.
// A result waits in the output register while dout stalls; the next sample
// may be taken and worked on meanwhile, holding in its last cycle until the
// output register is free.
// Reset (rst, synchronous) clears all stage state to zero, sets cutoff to
// 32768 and resonance to 0, and drops dout.valid.
module ladder_lowpass_filter #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS = 32
) (
  input logic clk,
  input logic rst,
  lpf_in_if.sink din,
  lpf_out_if.source dout,
  lpf_cfg_if.sink cfg
);
  localparam int AW = STATE_BITS;
  localparam int BW = lpf_pkg::COEF_BITS;
  localparam int RW = AW + 5;
  localparam int WW = AW + 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  localparam logic signed [WW-1:0] SMAX = {{(WW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = {{(WW-AW+1){1'b1}}, {(AW-1){1'b0}}};
  localparam logic signed [WW-1:0] OMAX =
    {{(WW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] OMIN =
    {{(WW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic signed [AW-1:0] sat_state(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > SMAX) r = SMAX;
    else if (v < SMIN) r = SMIN;
    else r = v;
    return r[AW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] ext(input logic signed [AW-1:0] v);
    return {{(WW-AW){v[AW-1]}}, v};
  endfunction

  logic [1:0] state;
  logic [lpf_pkg::STEP_BITS-1:0] step;
  logic [lpf_pkg::STEP_BITS-1:0] wb_step;

  logic [lpf_pkg::CUTOFF_BITS-1:0] cutoff;
  logic [lpf_pkg::RESON_BITS-1:0] resonance;

  logic signed [AW-1:0] i1, i2, i3, i4;
  logic signed [AW-1:0] o1, o2, o3, o4;
  logic signed [AW-1:0] s, q1, q2, q3, q4;
  logic signed [SAMPLE_BITS-1:0] x;

  logic [16:0] f, fsq, omt, f4;
  logic signed [17:0] omf;
  logic [18:0] fb;
  logic [15:0] gain;

  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [RW-1:0] r16;
  logic signed [AW+7:0] r13;
  logic signed [WW-1:0] r16w;
  logic signed [WW-1:0] o4w;
  logic out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  lpf_mul #(.AW(AW)) u_mul (
    .clk (clk),
    .a   (a_op),
    .b   (b_op),
    .r16 (r16),
    .r13 (r13)
  );

  assign din.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign dout.valid = out_valid;
  assign dout.sample_out = out_sample;

  assign wb_step = step - 5'd1;
  assign r16w = {{(WW-RW){r16[RW-1]}}, r16};
  assign o4w = ext(o4);

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (step)
      lpf_pkg::SQ_F: begin
        a_op = AW'(cutoff);
        b_op = BW'(lpf_pkg::K_1P16);
      end
      lpf_pkg::SQ_Q1: begin
        a_op = i1;
        b_op = BW'(lpf_pkg::K_0P3);
      end
      lpf_pkg::SQ_FSQ: begin
        a_op = AW'(f);
        b_op = BW'(f);
      end
      lpf_pkg::SQ_Q2: begin
        a_op = i2;
        b_op = BW'(lpf_pkg::K_0P3);
      end
      lpf_pkg::SQ_T: begin
        a_op = AW'(fsq);
        b_op = BW'(lpf_pkg::K_0P15);
      end
      lpf_pkg::SQ_F4: begin
        a_op = AW'(fsq);
        b_op = BW'(fsq);
      end
      lpf_pkg::SQ_FB: begin
        a_op = AW'(resonance);
        b_op = BW'(omt);
      end
      lpf_pkg::SQ_GAIN: begin
        a_op = AW'(f4);
        b_op = BW'(lpf_pkg::K_GAIN);
      end
      lpf_pkg::SQ_FBK: begin
        a_op = o4;
        b_op = BW'(fb);
      end
      lpf_pkg::SQ_Q3: begin
        a_op = i3;
        b_op = BW'(lpf_pkg::K_0P3);
      end
      lpf_pkg::SQ_SG: begin
        a_op = s;
        b_op = BW'(gain);
      end
      lpf_pkg::SQ_Q4: begin
        a_op = i4;
        b_op = BW'(lpf_pkg::K_0P3);
      end
      lpf_pkg::SQ_O1: begin
        a_op = o1;
        b_op = BW'(omf);
      end
      lpf_pkg::SQ_O2: begin
        a_op = o2;
        b_op = BW'(omf);
      end
      lpf_pkg::SQ_O3: begin
        a_op = o3;
        b_op = BW'(omf);
      end
      lpf_pkg::SQ_O4: begin
        a_op = o4;
        b_op = BW'(omf);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
      cutoff <= lpf_pkg::CUTOFF_RESET;
      resonance <= lpf_pkg::RESON_RESET;
      i1 <= '0;
      i2 <= '0;
      i3 <= '0;
      i4 <= '0;
      o1 <= '0;
      o2 <= '0;
      o3 <= '0;
      o4 <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          lpf_pkg::REG_CUTOFF: cutoff <= cfg.data[lpf_pkg::CUTOFF_BITS-1:0];
          lpf_pkg::REG_RESONANCE: resonance <= cfg.data[lpf_pkg::RESON_BITS-1:0];
          default: ;
        endcase
      end
      if (state == ST_OUT && (!out_valid || dout.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (din.valid) begin
            state <= ST_RUN;
            step <= '0;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          case (wb_step)
            lpf_pkg::SQ_O1: o1 <= sat_state(ext(s) + ext(q1) + r16w);
            lpf_pkg::SQ_O2: o2 <= sat_state(ext(o1) + ext(q2) + r16w);
            lpf_pkg::SQ_O3: o3 <= sat_state(ext(o2) + ext(q3) + r16w);
            lpf_pkg::SQ_O4: begin
              o4 <= sat_state(ext(o3) + ext(q4) + r16w);
              i1 <= s;
              i2 <= o1;
              i3 <= o2;
              i4 <= o3;
            end
            default: ;
          endcase
          if (step == lpf_pkg::SQ_END) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || dout.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && din.valid) x <= din.sample_in;
    if (state == ST_OUT && (!out_valid || dout.ready)) begin
      if (o4w > OMAX) out_sample <= OMAX[SAMPLE_BITS-1:0];
      else if (o4w < OMIN) out_sample <= OMIN[SAMPLE_BITS-1:0];
      else out_sample <= o4w[SAMPLE_BITS-1:0];
    end
    if (state == ST_RUN) begin
      case (wb_step)
        lpf_pkg::SQ_F: begin
          f <= r16[16:0];
          omf <= $signed({1'b0, lpf_pkg::K_ONE}) - $signed({1'b0, r16[16:0]});
        end
        lpf_pkg::SQ_Q1: q1 <= r16[AW-1:0];
        lpf_pkg::SQ_FSQ: fsq <= r16[16:0];
        lpf_pkg::SQ_Q2: q2 <= r16[AW-1:0];
        lpf_pkg::SQ_T: omt <= lpf_pkg::K_ONE - r16[16:0];
        lpf_pkg::SQ_F4: f4 <= r16[16:0];
        lpf_pkg::SQ_FB: fb <= r13[18:0];
        lpf_pkg::SQ_GAIN: gain <= r16[15:0];
        lpf_pkg::SQ_FBK:
          s <= sat_state({{(WW-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x} - r16w);
        lpf_pkg::SQ_Q3: q3 <= r16[AW-1:0];
        lpf_pkg::SQ_SG: s <= sat_state(r16w);
        lpf_pkg::SQ_Q4: q4 <= r16[AW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: bench/lpf_checker.sv
// Response checker for the ladder lowpass filter: follows register writes,
// predicts every filtered sample in fixed point and compares results in order.
// Depends on lpf_pkg and the channel interfaces of lpf_if.
module lpf_checker #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS = 32
) (
  input logic clk,
  input logic rst,
  lpf_in_if din,
  lpf_out_if dout,
  lpf_cfg_if cfg,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic [lpf_pkg::CUTOFF_BITS-1:0] cutoff_q;
  logic [lpf_pkg::RESON_BITS-1:0] reson_q;
  state_t prev_in [4];
  state_t prev_out [4];
  sample_t expected_samples [$];
  sample_t want;
  int mismatch_count = 0;

  assign errors = mismatch_count;

  function automatic longint q16_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one sample through feedback, gain and the four one-pole stages
  function automatic sample_t filter_step(sample_t x);
    longint f, fsq, t, fb, f4, gain, omf, s;
    longint stage [5];
    f = q16_mul(cutoff_q, lpf_pkg::K_1P16);
    fsq = q16_mul(f, f);
    t = q16_mul(fsq, lpf_pkg::K_0P15);
    fb = (longint'(reson_q) * (65536 - t) + 4096) >>> 13;
    f4 = q16_mul(fsq, fsq);
    gain = q16_mul(f4, lpf_pkg::K_GAIN);
    omf = 65536 - f;
    s = clamp(longint'(x) - q16_mul(prev_out[3], fb), STATE_BITS);
    stage[0] = clamp(q16_mul(s, gain), STATE_BITS);
    for (int k = 0; k < 4; k++)
      stage[k+1] = clamp(stage[k] + q16_mul(prev_in[k], lpf_pkg::K_0P3) +
                         q16_mul(prev_out[k], omf), STATE_BITS);
    for (int k = 0; k < 4; k++) begin
      prev_in[k] = state_t'(stage[k]);
      prev_out[k] = state_t'(stage[k+1]);
    end
    return sample_t'(clamp(stage[4], SAMPLE_BITS));
  endfunction

  task automatic report_mismatch(string what, sample_t got, sample_t exp_val);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cutoff_q = lpf_pkg::CUTOFF_RESET;
      reson_q = lpf_pkg::RESON_RESET;
      for (int k = 0; k < 4; k++) begin
        prev_in[k] = '0;
        prev_out[k] = '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lpf_pkg::REG_CUTOFF: cutoff_q = cfg.data[lpf_pkg::CUTOFF_BITS-1:0];
          lpf_pkg::REG_RESONANCE: reson_q = cfg.data[lpf_pkg::RESON_BITS-1:0];
          default: ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample_out with no item pending", dout.sample_out, '0);
        end else begin
          want = expected_samples.pop_front();
          if (dout.sample_out !== want)
            report_mismatch("sample_out", dout.sample_out, want);
        end
      end
      if (din.valid && din.ready)
        expected_samples.push_back(filter_step(din.sample_in));
    end
    pending = expected_samples.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the ladder lowpass filter testbench: clock, reset, register writes,
// sample stimulus with random idling on both channels, and the verdict.
// Depends on lpf_pkg, lpf_if, ladder_lowpass_filter and lpf_checker.
module tb ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [23:0] sample_t;
  typedef logic [lpf_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [lpf_pkg::CFG_DATA_BITS-1:0] cfg_data_t;
  typedef logic [lpf_pkg::CUTOFF_BITS-1:0] cutoff_t;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 102;
  localparam int LONG_HOLD = 400;
  localparam cfg_index_t REG_SPARE = lpf_pkg::REG_RESONANCE + 1'b1;
  localparam cfg_index_t REG_TOP = '1;
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors, pending;
  int cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit long_hold_req = 1'b0;

  lpf_in_if din ();
  lpf_out_if dout ();
  lpf_cfg_if cfg ();

  ladder_lowpass_filter DUT (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg));

  lpf_checker response_check (
    .clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_sample(input sample_t v);
    int gap;
    gap = draw_gap(in_burst);
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    @(negedge clk);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid <= 1'b1;
    din.sample_in <= v;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    din.valid <= 1'b0;
    wait (pending == 0);
  endtask

  // result side
  initial begin
    int gap;
    bit hold_taken;
    hold_taken = 1'b0;
    dout.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        gap = LONG_HOLD;
        hold_taken = 1'b1;
      end else begin
        gap = draw_gap(out_burst);
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      end
      if (gap > 0) begin
        dout.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      dout.ready <= 1'b1;
      @(posedge clk);
      while (!dout.valid) @(posedge clk);
    end
  end

  initial begin
    sample_t v;
    cutoff_t cut;
    cfg_data_t res;
    din.valid = 1'b0;
    din.sample_in = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: extremes, sign flips, alternating bit patterns
    send_sample('0);
    repeat (4) send_sample(S_MAX);
    repeat (4) send_sample(S_MIN);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    drain();

    // cutoff above one, full resonance with the spare data bit, dead indexes
    write_reg(lpf_pkg::REG_CUTOFF, 16'hFFFF);
    write_reg(lpf_pkg::REG_RESONANCE, 16'hFFFF);
    write_reg(REG_SPARE, 16'h1234);
    write_reg(REG_TOP, 16'h0000);
    repeat (4) begin
      send_sample(S_MAX);
      send_sample(S_MIN);
    end
    drain();

    write_reg(lpf_pkg::REG_CUTOFF, 16'h0000);
    write_reg(lpf_pkg::REG_RESONANCE, 16'h0000);
    send_sample(S_MAX);
    send_sample(S_MIN);
    drain();

    v = '0;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: cut = '0;
        1: cut = '1;
        2: cut = 16'd56500;
        default: cut = cutoff_t'($urandom_range(3000, 65535));
      endcase
      case ($urandom_range(0, 5))
        0: res = '0;
        1: res = 16'h7FFF;
        default: res = cfg_data_t'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(cfg_index_t'(REG_SPARE + $urandom_range(0, 200)),
                  cfg_data_t'($urandom_range(0, 65535)));
      write_reg(lpf_pkg::REG_CUTOFF, cut);
      write_reg(lpf_pkg::REG_RESONANCE, res);
      if (p == 3) begin
        long_hold_req = 1'b1;
        in_burst = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = sample_t'($urandom_range(0, 2000)) - 24'sd1000;
          3: ;
          default: v = sample_t'($urandom);
        endcase
        send_sample(v);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
